/* rtl/nfcs_pkg.sv */
// Shared types, codes and constants of the NOR flash command sequencer.
package nfcs_pkg;

  localparam int AddrBitsDefault   = 24;
  localparam int QueueDepthDefault = 4;

  localparam int AddrW   = 24;
  localparam int DataW   = 16;
  localparam int CfgW    = 26;
  localparam int CfgIdxW = 3;

  // Command codes carried in the mode field
  localparam logic [2:0] MODE_PROGRAM      = 3'd0;
  localparam logic [2:0] MODE_ERASE_SECTOR = 3'd1;
  localparam logic [2:0] MODE_ERASE_BLOCK  = 3'd2;
  localparam logic [2:0] MODE_ERASE_CHIP   = 3'd3;
  localparam logic [2:0] MODE_READ_ID      = 3'd4;
  localparam logic [2:0] MODE_READ_RETURN  = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FLASH_BYTES   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SECTOR_BYTES  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_BYTES   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_UNLOCK_ADDR_A = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_UNLOCK_ADDR_B = 3'd4;

  localparam logic [25:0] FLASH_BYTES_RST   = 26'd2097152;
  localparam logic [24:0] SECTOR_BYTES_RST  = 25'd4096;
  localparam logic [24:0] BLOCK_BYTES_RST   = 25'd65536;
  localparam logic [23:0] UNLOCK_ADDR_A_RST = 24'h005555;
  localparam logic [23:0] UNLOCK_ADDR_B_RST = 24'h002AAA;

  // JEDEC command bytes
  localparam logic [DataW-1:0] CMD_UNLOCK1      = 16'h00AA;
  localparam logic [DataW-1:0] CMD_UNLOCK2      = 16'h0055;
  localparam logic [DataW-1:0] CMD_PROGRAM      = 16'h00A0;
  localparam logic [DataW-1:0] CMD_ERASE_SETUP  = 16'h0080;
  localparam logic [DataW-1:0] CMD_SECTOR_ERASE = 16'h0030;
  localparam logic [DataW-1:0] CMD_BLOCK_ERASE  = 16'h0050;
  localparam logic [DataW-1:0] CMD_CHIP_ERASE   = 16'h0010;
  localparam logic [DataW-1:0] CMD_ID_ENTRY     = 16'h0090;
  localparam logic [DataW-1:0] CMD_ID_EXIT      = 16'h00F0;
  localparam logic [DataW-1:0] BLANK_WORD       = 16'hFFFF;
  localparam int               TOGGLE_BIT       = 6;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_RANGE     = 2'd0,
    ERR_NOT_BLANK = 2'd1,
    ERR_BUSY      = 2'd2
  } err_e;

  // Bus cycle runs handed from the front end to the back end
  typedef enum logic [3:0] {
    RUN_ERROR,
    RUN_PROG_READ,
    RUN_PROG_WRITE,
    RUN_ERASE_SECTOR,
    RUN_ERASE_BLOCK,
    RUN_ERASE_CHIP,
    RUN_ID_ENTER,
    RUN_ID_READ1,
    RUN_ID_EXIT,
    RUN_POLL_READ,
    RUN_DONE
  } run_e;

  typedef struct packed {
    logic [25:0] flash_bytes;
    logic [24:0] sector_bytes;
    logic [24:0] block_bytes;
    logic [23:0] unlock_a;
    logic [23:0] unlock_b;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [24:0]      byte_offset;
    logic [15:0]      region_index;
    logic [DataW-1:0] data_word;
  } item_t;

  // data: error code, program word or maker id; aux: region index or device id
  typedef struct packed {
    run_e             run;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic [DataW-1:0] aux;
  } desc_t;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    err_e             err;
    logic [DataW-1:0] maker;
    logic [DataW-1:0] device;
    logic             last;
  } result_t;

  function automatic logic [AddrW-1:0] addr_mask(int bits);
    logic [63:0] m;
    m = (64'd1 << bits) - 64'd1;
    return m[AddrW-1:0];
  endfunction

endpackage

/* rtl/nfcs_front.sv */
// Front end: accepts commands and read returns, tracks the protocol phase, queues runs.
module nfcs_front #(
  parameter int ADDR_BITS = nfcs_pkg::AddrBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  nfcs_pkg::item_t item_i,
  input  logic [25:0]     flash_bytes_i,
  output logic            push_o,
  output nfcs_pkg::desc_t desc_o
);
  import nfcs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BLANK,
    PH_POLL,
    PH_ID_MAKER,
    PH_ID_DEVICE
  } phase_e;

  localparam logic [AddrW-1:0] AddrMask = addr_mask(ADDR_BITS);

  phase_e           phase_q, phase_d;
  logic [AddrW-1:0] target_q, target_d;
  logic [DataW-1:0] prog_q, prog_d;
  logic [DataW-1:0] maker_q, maker_d;
  logic             toggle_q, toggle_d;
  logic             first_q, first_d;
  logic             bit6;

  always_comb begin
    phase_d  = phase_q;
    target_d = target_q;
    prog_d   = prog_q;
    maker_d  = maker_q;
    toggle_d = toggle_q;
    first_d  = first_q;
    push_o   = 1'b0;
    desc_o   = '{run: RUN_DONE, addr: '0, data: '0, aux: '0};
    bit6     = item_i.data_word[TOGGLE_BIT];

    if (accept_i) begin
      if (item_i.mode <= MODE_READ_ID && phase_q != PH_IDLE) begin
        // Command while a run is open: report busy, keep state
        push_o      = 1'b1;
        desc_o.run  = RUN_ERROR;
        desc_o.data = DataW'(ERR_BUSY);
      end else begin
        unique case (item_i.mode)
          MODE_PROGRAM: begin
            push_o = 1'b1;
            if ({1'b0, item_i.byte_offset} >= flash_bytes_i) begin
              desc_o.run  = RUN_ERROR;
              desc_o.data = DataW'(ERR_RANGE);
            end else begin
              target_d    = item_i.byte_offset[24:1] & AddrMask;
              prog_d      = item_i.data_word;
              desc_o.run  = RUN_PROG_READ;
              desc_o.addr = item_i.byte_offset[24:1] & AddrMask;
              phase_d     = PH_BLANK;
            end
          end
          MODE_ERASE_SECTOR, MODE_ERASE_BLOCK, MODE_ERASE_CHIP: begin
            push_o     = 1'b1;
            desc_o.aux = item_i.region_index;
            desc_o.run = (item_i.mode == MODE_ERASE_SECTOR) ? RUN_ERASE_SECTOR :
                         (item_i.mode == MODE_ERASE_BLOCK)  ? RUN_ERASE_BLOCK  :
                                                              RUN_ERASE_CHIP;
            first_d    = 1'b1;
            phase_d    = PH_POLL;
          end
          MODE_READ_ID: begin
            push_o     = 1'b1;
            desc_o.run = RUN_ID_ENTER;
            phase_d    = PH_ID_MAKER;
          end
          MODE_READ_RETURN: begin
            unique case (phase_q)
              PH_BLANK: begin
                push_o = 1'b1;
                if (item_i.data_word != BLANK_WORD) begin
                  desc_o.run  = RUN_ERROR;
                  desc_o.data = DataW'(ERR_NOT_BLANK);
                  phase_d     = PH_IDLE;
                end else begin
                  desc_o.run  = RUN_PROG_WRITE;
                  desc_o.addr = target_q;
                  desc_o.data = prog_q;
                  first_d     = 1'b1;
                  phase_d     = PH_POLL;
                end
              end
              PH_POLL: begin
                push_o = 1'b1;
                if (first_q) begin
                  first_d    = 1'b0;
                  toggle_d   = bit6;
                  desc_o.run = RUN_POLL_READ;
                end else if (bit6 == toggle_q) begin
                  desc_o.run = RUN_DONE;
                  phase_d    = PH_IDLE;
                end else begin
                  toggle_d   = bit6;
                  desc_o.run = RUN_POLL_READ;
                end
              end
              PH_ID_MAKER: begin
                push_o     = 1'b1;
                maker_d    = item_i.data_word;
                desc_o.run = RUN_ID_READ1;
                phase_d    = PH_ID_DEVICE;
              end
              PH_ID_DEVICE: begin
                push_o      = 1'b1;
                desc_o.run  = RUN_ID_EXIT;
                desc_o.data = maker_q;
                desc_o.aux  = item_i.data_word;
                phase_d     = PH_IDLE;
              end
              default: phase_d = PH_IDLE;  // stray return: drop it
            endcase
          end
          default: ;  // undefined modes: drop
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      target_q <= '0;
      prog_q   <= '0;
      maker_q  <= '0;
      toggle_q <= 1'b0;
      first_q  <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      target_q <= target_d;
      prog_q   <= prog_d;
      maker_q  <= maker_d;
      toggle_q <= toggle_d;
      first_q  <= first_d;
    end
  end

endmodule

/* rtl/nfcs_queue.sv */
// Short run queue between the front end and the back end.
module nfcs_queue #(
  parameter int DEPTH = nfcs_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nfcs_pkg::desc_t desc_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            avail_o,
  output nfcs_pkg::desc_t head_o
);
  import nfcs_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  desc_t           mem [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/nfcs_back.sv */
// Back end: expands each queued run into bus cycle results, one per cycle unless out_ready_i stalls the output.
module nfcs_back #(
  parameter int ADDR_BITS = nfcs_pkg::AddrBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nfcs_pkg::cfg_t    cfg_i,
  input  logic              avail_i,
  input  nfcs_pkg::desc_t   head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nfcs_pkg::result_t out_o
);
  import nfcs_pkg::*;

  localparam logic [AddrW-1:0] AddrMask = addr_mask(ADDR_BITS);

  desc_t            cur_q;
  logic             cur_valid_q;
  logic [2:0]       step_q;
  logic [40:0]      prod_q;
  result_t          out_q;
  logic             out_valid_q;

  result_t          res;
  logic             advance;
  logic             fire;
  logic [AddrW-1:0] unlock_addr;
  logic [DataW-1:0] unlock_data;
  logic [DataW-1:0] cmd;
  logic [24:0]      size_sel;

  assign advance     = !out_valid_q || out_ready_i;
  assign fire        = advance && cur_valid_q;
  assign pop_o       = avail_i && (!cur_valid_q || (fire && res.last));
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign size_sel    = (cur_q.run == RUN_ERASE_BLOCK) ? cfg_i.block_bytes : cfg_i.sector_bytes;

  always_comb begin
    case (cur_q.run)
      RUN_ID_ENTER:   cmd = CMD_ID_ENTRY;
      RUN_PROG_WRITE: cmd = CMD_PROGRAM;
      RUN_ID_EXIT:    cmd = CMD_ID_EXIT;
      default:        cmd = CMD_ERASE_SETUP;
    endcase
    // Unlock pattern: AA at A, 55 at B, command at A; erase repeats AA/55
    unlock_addr = ((step_q == 3'd1 || step_q == 3'd4) ? cfg_i.unlock_b : cfg_i.unlock_a)
                  & AddrMask;
    unlock_data = (step_q == 3'd0 || step_q == 3'd3) ? CMD_UNLOCK1 :
                  (step_q == 3'd1 || step_q == 3'd4) ? CMD_UNLOCK2 : cmd;
  end

  always_comb begin
    res = '{kind: KIND_WRITE, addr: '0, data: '0, err: ERR_RANGE,
            maker: '0, device: '0, last: 1'b0};
    unique case (cur_q.run)
      RUN_ERROR: begin
        res.kind = KIND_ERROR;
        res.err  = err_e'(cur_q.data[1:0]);
        res.last = 1'b1;
      end
      RUN_PROG_READ: begin
        res.kind = KIND_READ;
        res.addr = cur_q.addr;
        res.last = 1'b1;
      end
      RUN_POLL_READ: begin
        res.kind = KIND_READ;
        res.last = 1'b1;
      end
      RUN_DONE: begin
        res.kind = KIND_DONE;
        res.last = 1'b1;
      end
      RUN_ID_READ1: begin
        res.kind = KIND_READ;
        res.addr = AddrW'(1);
        res.last = 1'b1;
      end
      RUN_ID_ENTER: begin
        if (step_q < 3'd3) begin
          res.addr = unlock_addr;
          res.data = unlock_data;
        end else begin
          res.kind = KIND_READ;
          res.last = 1'b1;
        end
      end
      RUN_PROG_WRITE: begin
        if (step_q < 3'd3) begin
          res.addr = unlock_addr;
          res.data = unlock_data;
        end else if (step_q == 3'd3) begin
          res.addr = cur_q.addr;
          res.data = cur_q.data;
        end else begin
          res.kind = KIND_READ;
          res.last = 1'b1;
        end
      end
      RUN_ID_EXIT: begin
        if (step_q < 3'd3) begin
          res.addr = unlock_addr;
          res.data = unlock_data;
        end else begin
          res.kind   = KIND_DONE;
          res.maker  = cur_q.data;
          res.device = cur_q.aux;
          res.last   = 1'b1;
        end
      end
      RUN_ERASE_SECTOR, RUN_ERASE_BLOCK, RUN_ERASE_CHIP: begin
        if (step_q < 3'd5) begin
          res.addr = unlock_addr;
          res.data = unlock_data;
        end else if (step_q == 3'd5) begin
          if (cur_q.run == RUN_ERASE_CHIP) begin
            res.addr = cfg_i.unlock_a & AddrMask;
            res.data = CMD_CHIP_ERASE;
          end else begin
            res.addr = prod_q[24:1] & AddrMask;
            res.data = (cur_q.run == RUN_ERASE_SECTOR) ? CMD_SECTOR_ERASE : CMD_BLOCK_ERASE;
          end
        end else begin
          res.kind = KIND_READ;
          res.last = 1'b1;
        end
      end
      default: res.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '{run: RUN_DONE, addr: '0, data: '0, aux: '0};
      cur_valid_q <= 1'b0;
      step_q      <= '0;
      prod_q      <= '0;
      out_q       <= '{kind: KIND_WRITE, addr: '0, data: '0, err: ERR_RANGE,
                       maker: '0, device: '0, last: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      // Region address product; ready long before the erase target cycle
      prod_q <= 41'(cur_q.aux) * 41'(size_sel);
      if (advance) begin
        out_valid_q <= cur_valid_q;
        out_q       <= res;
      end
      if (pop_o) begin
        cur_q       <= head_i;
        cur_valid_q <= 1'b1;
        step_q      <= '0;
      end else if (fire) begin
        if (res.last) begin
          cur_valid_q <= 1'b0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/nor_flash_command_sequencer.sv */
// Top level of the JEDEC NOR flash command sequencer: config registers, ports, checks.
// Path: a transaction's run passes the run queue, the back end's current-run register and
//   the output register before its first bus cycle leaves. Throughput: one result per cycle
//   unless m_axis_tready stalls the output, one per bus cycle of its run as set by the
//   back-end sequencer; inputs are taken every cycle while the run queue has room.
// Reset: rst_ni clears phase, queue and output register at once; config registers
//   return to their defaults. No clearing pass.
module nor_flash_command_sequencer #(
  parameter int ADDR_BITS   = nfcs_pkg::AddrBitsDefault,
  parameter int QUEUE_DEPTH = nfcs_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input transactions
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // byte_offset, region_index, data_word
  input  logic [2:0]                   s_axis_tuser,  // mode
  // Result transactions
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // bus_address, bus_data, error_code, maker_id, device_id
  output logic [79:0]                  m_axis_tdata,
  output logic [1:0]                   m_axis_tuser,  // cycle_kind
  output logic                         m_axis_tlast,
  // Configuration writes
  input  logic                         cfg_we_i,
  input  logic [nfcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [nfcs_pkg::CfgW-1:0]    cfg_data_i
);
  import nfcs_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  desc_t   push_desc;
  desc_t   head;
  result_t res;
  logic    accept;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_avail;

  // Configuration registers; writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{flash_bytes: FLASH_BYTES_RST, sector_bytes: SECTOR_BYTES_RST,
                 block_bytes: BLOCK_BYTES_RST, unlock_a: UNLOCK_ADDR_A_RST,
                 unlock_b: UNLOCK_ADDR_B_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FLASH_BYTES:   cfg_q.flash_bytes  <= cfg_data_i;
        CFG_SECTOR_BYTES:  cfg_q.sector_bytes <= cfg_data_i[24:0];
        CFG_BLOCK_BYTES:   cfg_q.block_bytes  <= cfg_data_i[24:0];
        CFG_UNLOCK_ADDR_A: cfg_q.unlock_a     <= cfg_data_i[23:0];
        CFG_UNLOCK_ADDR_B: cfg_q.unlock_b     <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Take an input transaction whenever the run queue can hold its run
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign item.mode         = s_axis_tuser;
  assign item.byte_offset  = s_axis_tdata[24:0];
  assign item.region_index = s_axis_tdata[40:25];
  assign item.data_word    = s_axis_tdata[56:41];

  nfcs_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (item),
    .flash_bytes_i(cfg_q.flash_bytes),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  nfcs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .pop_i  (pop),
    .full_o (q_full),
    .avail_o(q_avail),
    .head_o (head)
  );

  nfcs_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .avail_i    (q_avail),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_o      (res)
  );

  // Pack results: address lowest, then data, error code, maker id, device id
  assign m_axis_tdata = {6'b0, res.device, res.maker, res.err, res.data, res.addr};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  // An error result always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.kind == KIND_ERROR) |-> res.last)
    else $error("error result without tlast");

  // Error codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.kind == KIND_ERROR) |->
      (res.err == ERR_RANGE || res.err == ERR_NOT_BLANK || res.err == ERR_BUSY))
    else $error("undefined error code");

  // Only bus writes carry data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.kind != KIND_WRITE) |-> (res.data == '0))
    else $error("data on a non-write result");

  // Identifier fields appear only on a done result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.kind != KIND_DONE) |-> (res.maker == '0 && res.device == '0))
    else $error("id fields on a non-done result");

endmodule
